>>> src/gfalu_pkg.sv
// Package for the GF(2^W) arithmetic unit: field constants, opcodes, log/antilog tables.
package gfalu_pkg;

    // Field definition
    localparam int FIELD_WIDTH    = 8;
    localparam int PRIMITIVE_POLY = 285;
    localparam int FIELD_SIZE     = 1 << FIELD_WIDTH;
    localparam int GROUP_ORDER    = FIELD_SIZE - 1;

    // Exponent is serialized MSB first, one bit per cycle
    localparam int EXP_WIDTH = 16;
    localparam int CNT_WIDTH = $clog2(EXP_WIDTH);

    // Operation codes
    localparam logic [1:0] OP_MUL = 2'd0;
    localparam logic [1:0] OP_DIV = 2'd1;
    localparam logic [1:0] OP_POW = 2'd2;

    typedef logic [FIELD_WIDTH-1:0] elem_t;
    typedef elem_t tab_t [FIELD_SIZE];

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOG,
        ST_POW,
        ST_OUT
    } state_t;

    // Next power of the generator, reduced by the primitive polynomial
    function automatic logic [FIELD_WIDTH:0] gen_step(input logic [FIELD_WIDTH:0] v);
        logic [FIELD_WIDTH:0] n;
        n = {v[FIELD_WIDTH-1:0], 1'b0};
        if (n[FIELD_WIDTH]) begin
            n = n ^ (FIELD_WIDTH + 1)'(PRIMITIVE_POLY);
        end
        n[FIELD_WIDTH] = 1'b0;
        return n;
    endfunction

    // log_table[x^k] = k; evaluated at elaboration only
    function automatic tab_t gen_log_table();
        tab_t t;
        logic [FIELD_WIDTH:0] v;
        for (int k = 0; k < FIELD_SIZE; k++) begin
            t[k] = '0;
        end
        v = (FIELD_WIDTH + 1)'(1);
        for (int k = 0; k < GROUP_ORDER; k++) begin
            t[v[FIELD_WIDTH-1:0]] = FIELD_WIDTH'(k);
            v = gen_step(v);
        end
        return t;
    endfunction

    // antilog_table[k] = x^k; last entry stays zero
    function automatic tab_t gen_antilog_table();
        tab_t t;
        logic [FIELD_WIDTH:0] v;
        for (int k = 0; k < FIELD_SIZE; k++) begin
            t[k] = '0;
        end
        v = (FIELD_WIDTH + 1)'(1);
        for (int k = 0; k < GROUP_ORDER; k++) begin
            t[k] = v[FIELD_WIDTH-1:0];
            v = gen_step(v);
        end
        return t;
    endfunction

    localparam tab_t LOG_TABLE     = gen_log_table();
    localparam tab_t ANTILOG_TABLE = gen_antilog_table();

    // Reduce a value below twice the group order into [0, GROUP_ORDER)
    function automatic elem_t mod_order(input logic [FIELD_WIDTH:0] x);
        logic [FIELD_WIDTH:0] r;
        r = x;
        if (x >= (FIELD_WIDTH + 1)'(GROUP_ORDER)) begin
            r = x - (FIELD_WIDTH + 1)'(GROUP_ORDER);
        end
        return r[FIELD_WIDTH-1:0];
    endfunction

endpackage

>>> src/galois_field_alu_core.sv
// Top level of the GF(2^W) arithmetic unit: multiply, divide and power.
//
// Usage:
//   Input channel (s_valid/s_ready) carries one word: s_operation selects
//   multiply, divide a by b, or a raised to the 16-bit exponent b. Result
//   channel (m_valid/m_ready) returns one word per input word: m_result and
//   m_divide_by_zero (set only for a divide with nonzero a and zero b).
//   Multiply and divide: state ST_LOG does the log lookups and the modular
//   add or subtract, then state ST_OUT does the antilog lookup into the output
//   register and raises m_valid.
//   Power: after ST_LOG, state ST_POW shifts the exponent in MSB first, one
//   bit per cycle, through a modular double-and-add on log(a); ST_OUT then
//   writes the result through the antilog lookup into the output register.
//   One word is in flight at a time; s_ready is high whenever the datapath
//   is idle, even while a finished result waits in the output register.
//   If the receiver stalls, the result holds in the output register and the
//   datapath waits in its final state until that register frees up.
//   Reset (aresetn low, synchronous) returns the sequencer to idle and drops
//   m_valid. Log and antilog tables are constants and need no fill time.
module galois_field_alu_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_operation,
    input  logic [7:0]  s_operand_a,
    input  logic [15:0] s_operand_b,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_result,
    output logic        m_divide_by_zero
);

    localparam int FW = gfalu_pkg::FIELD_WIDTH;

    gfalu_pkg::state_t state_reg, state_next;

    logic [1:0]                         op_reg;
    gfalu_pkg::elem_t                   a_reg;
    logic [gfalu_pkg::EXP_WIDTH-1:0]    b_reg, b_next;
    logic                               e_zero_reg, e_one_reg;
    gfalu_pkg::elem_t                   la_reg, la_next;
    gfalu_pkg::elem_t                   k_reg, k_next;
    logic [gfalu_pkg::CNT_WIDTH-1:0]    cnt_reg, cnt_next;

    logic             m_valid_reg, m_valid_next;
    logic [7:0]       m_result_reg, m_result_next;
    logic             m_dbz_reg, m_dbz_next;

    gfalu_pkg::elem_t la_lut, lb_lut;
    gfalu_pkg::elem_t pow_dbl, pow_add;
    gfalu_pkg::elem_t alog_val;
    logic             a_zero, b_zero, accept, out_free;

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == gfalu_pkg::ST_IDLE);

    // Table lookups
    assign la_lut   = gfalu_pkg::LOG_TABLE[a_reg];
    assign lb_lut   = gfalu_pkg::LOG_TABLE[b_reg[FW-1:0]];
    assign alog_val = gfalu_pkg::ANTILOG_TABLE[k_reg];
    assign a_zero   = (a_reg == '0);
    assign b_zero   = (b_reg[FW-1:0] == '0);

    // One exponent bit: k = (2k + bit*log a) mod order
    assign pow_dbl = gfalu_pkg::mod_order({k_reg, 1'b0});
    assign pow_add = gfalu_pkg::mod_order({1'b0, pow_dbl}
                     + (b_reg[gfalu_pkg::EXP_WIDTH-1] ? {1'b0, la_reg} : '0));

    // Operand capture
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg     <= s_operation;
            a_reg      <= s_operand_a[FW-1:0];
            e_zero_reg <= (s_operand_b == '0);
            e_one_reg  <= (s_operand_b == gfalu_pkg::EXP_WIDTH'(1));
        end
        b_reg  <= b_next;
        la_reg <= la_next;
        k_reg  <= k_next;
    end

    // Control and output registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= gfalu_pkg::ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
        m_result_reg <= m_result_next;
        m_dbz_reg    <= m_dbz_next;
    end

    // Sequencer and datapath next values
    always_comb begin
        state_next    = state_reg;
        b_next        = b_reg;
        la_next       = la_reg;
        k_next        = k_reg;
        cnt_next      = cnt_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_result_next = m_result_reg;
        m_dbz_next    = m_dbz_reg;

        case (state_reg)
            gfalu_pkg::ST_IDLE: begin
                if (accept) begin
                    b_next     = s_operand_b;
                    state_next = gfalu_pkg::ST_LOG;
                end
            end
            gfalu_pkg::ST_LOG: begin
                la_next = la_lut;
                if (op_reg == gfalu_pkg::OP_POW) begin
                    k_next     = '0;
                    cnt_next   = '1;
                    state_next = gfalu_pkg::ST_POW;
                end else begin
                    if (op_reg == gfalu_pkg::OP_DIV) begin
                        k_next = gfalu_pkg::mod_order({1'b0, la_lut}
                                 + (FW + 1)'(gfalu_pkg::GROUP_ORDER) - {1'b0, lb_lut});
                    end else begin
                        k_next = gfalu_pkg::mod_order({1'b0, la_lut} + {1'b0, lb_lut});
                    end
                    state_next = gfalu_pkg::ST_OUT;
                end
            end
            gfalu_pkg::ST_POW: begin
                k_next   = pow_add;
                b_next   = {b_reg[gfalu_pkg::EXP_WIDTH-2:0], 1'b0};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = gfalu_pkg::ST_OUT;
                end
            end
            gfalu_pkg::ST_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_dbz_next   = 1'b0;
                    case (op_reg)
                        gfalu_pkg::OP_MUL: begin
                            m_result_next = (a_zero || b_zero) ? '0 : 8'(alog_val);
                        end
                        gfalu_pkg::OP_DIV: begin
                            m_result_next = (a_zero || b_zero) ? '0 : 8'(alog_val);
                            m_dbz_next    = !a_zero && b_zero;
                        end
                        gfalu_pkg::OP_POW: begin
                            if (e_zero_reg) begin
                                m_result_next = 8'd1;
                            end else if (e_one_reg) begin
                                m_result_next = 8'(a_reg);
                            end else if (a_zero) begin
                                m_result_next = '0;
                            end else begin
                                m_result_next = 8'(alog_val);
                            end
                        end
                        default: begin
                            m_result_next = '0;
                        end
                    endcase
                    state_next = gfalu_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = gfalu_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_valid          = m_valid_reg;
    assign m_result         = m_result_reg;
    assign m_divide_by_zero = m_dbz_reg;

endmodule

>>> src/gfalu_checker.sv
// Port-level checker for the GF(2^W) arithmetic unit, bound to the top level.
module gfalu_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [7:0]  m_result,
    input logic        m_divide_by_zero
);

    // Reset empties the output register
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("m_valid high after reset");

    // Stalled result word holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result) && $stable(m_divide_by_zero))
        else $error("stalled result word changed");

    // Divide error always reports a zero result
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_divide_by_zero |-> m_result == 8'd0)
        else $error("divide error with nonzero result");

    // One word in flight: input closes right after an accept
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second word accepted while busy");

endmodule

bind galois_field_alu_core gfalu_checker u_gfalu_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_valid          (s_valid),
    .s_ready          (s_ready),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_result         (m_result),
    .m_divide_by_zero (m_divide_by_zero)
);
